/* rtl/assert_macros.svh */
// Assertion macros used by the frame parser module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define WSFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define WSFP_NEVER(label, clk, rst, cond, msg) \
   `WSFP_ASSERT(label, clk, rst, !(cond), msg)

`endif

/* rtl/wsfp_pkg.sv */
// Types and constants shared by the frame parser modules.
package wsfp_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 63;
   localparam int ACC_W  = 64;
   localparam int KEY_W  = 32;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 63'd1024;

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   localparam logic [2:0] EXT16_LAST_CNT = 3'd1;
   localparam logic [2:0] EXT64_LAST_CNT = 3'd7;
   localparam logic [2:0] KEY_LAST_CNT   = 3'd3;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_EXT16,
      PH_EXT64,
      PH_MASK,
      PH_PAYLOAD,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              fin;
      logic [2:0]        rsv_bits;
      logic [3:0]        opcode;
      logic              masked;
      logic [LEN_W-1:0]  payload_length;
      logic [BYTE_W-1:0] data_byte;
      logic              last_of_frame;
   } result_type;

endpackage

/* rtl/wsfp_if.sv */
// Channel interfaces: received bytes, parse results and the length limit write.
interface wsfp_req_if;
   logic                        valid;
   logic                        ready;
   logic [wsfp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfp_rsp_if;
   logic                        valid;
   logic                        ready;
   wsfp_pkg::kind_type          kind;
   logic                        fin;
   logic [2:0]                  rsv_bits;
   logic [3:0]                  opcode;
   logic                        masked;
   logic [wsfp_pkg::LEN_W-1:0]  payload_length;
   logic [wsfp_pkg::BYTE_W-1:0] data_byte;
   logic                        last_of_frame;

   modport source (output valid, output kind, output fin, output rsv_bits, output opcode,
                   output masked, output payload_length, output data_byte,
                   output last_of_frame, input ready);
   modport sink   (input valid, input kind, input fin, input rsv_bits, input opcode,
                   input masked, input payload_length, input data_byte,
                   input last_of_frame, output ready);
endinterface

interface wsfp_csr_if;
   logic                       valid;
   logic                       ready;
   logic [wsfp_pkg::LEN_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/wsfp_parser.sv */
// Header and payload parse state with the per-byte next-state and result logic.
`include "assert_macros.svh"

module wsfp_parser (
   input  logic                       clock,
   input  logic                       reset,
   wsfp_req_if.sink                   req_if,
   input  logic                       take_ok,
   input  logic [wsfp_pkg::LEN_W-1:0] max_len,
   output logic                       res_valid,
   output wsfp_pkg::result_type       res
);

   wsfp_pkg::phase_type         phase_ff, phase_in;
   logic [7:0]                  hdr_ff, hdr_in;
   logic                        mask_ff, mask_in;
   logic [wsfp_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [2:0]                  cnt_ff, cnt_in;
   logic [wsfp_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [wsfp_pkg::ACC_W-1:0]  rem_ff, rem_in;
   logic [1:0]                  kp_ff, kp_in;

   logic                        accept;
   logic [wsfp_pkg::BYTE_W-1:0] b;
   logic [6:0]                  code;
   logic                        code_ext;
   logic                        mask_now;
   logic                        len_over;
   logic                        len_zero;
   logic                        known_now;
   logic                        hdr_now;
   logic                        rem_last;
   logic [wsfp_pkg::BYTE_W-1:0] key_byte;
   logic                        raw_valid;

   assign req_if.ready = take_ok;
   assign accept       = req_if.valid && take_ok;
   assign b            = req_if.rx_byte;
   assign code         = b[6:0];
   assign code_ext     = (code == wsfp_pkg::LEN_CODE_EXT16) || (code == wsfp_pkg::LEN_CODE_EXT64);

   // Length accumulator: seeded by the second byte, shifted in big-endian order.
   always_comb begin
      case (phase_ff)
         wsfp_pkg::PH_SECOND: begin
            acc_in = code_ext ? '0 : {{(wsfp_pkg::ACC_W-7){1'b0}}, code};
         end
         wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
            acc_in = {acc_ff[wsfp_pkg::ACC_W-wsfp_pkg::BYTE_W-1:0], b};
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   assign mask_now = (phase_ff == wsfp_pkg::PH_SECOND) ? b[7] : mask_ff;
   assign len_over = acc_in > {1'b0, max_len};
   assign len_zero = (acc_in == '0);
   assign rem_last = (rem_ff == {{(wsfp_pkg::ACC_W-1){1'b0}}, 1'b1});

   assign known_now = ((phase_ff == wsfp_pkg::PH_SECOND) && !code_ext)
                   || ((phase_ff == wsfp_pkg::PH_EXT16) && (cnt_ff == wsfp_pkg::EXT16_LAST_CNT))
                   || ((phase_ff == wsfp_pkg::PH_EXT64) && (cnt_ff == wsfp_pkg::EXT64_LAST_CNT));

   assign hdr_now = (known_now && !len_over && !mask_now)
                 || ((phase_ff == wsfp_pkg::PH_MASK) && (cnt_ff == wsfp_pkg::KEY_LAST_CNT));

   // Key byte for the current payload position, first key byte in the top bits.
   always_comb begin
      case (kp_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      mask_in  = mask_ff;
      cnt_in   = cnt_ff;
      key_in   = key_ff;
      rem_in   = rem_ff;
      kp_in    = kp_ff;
      case (phase_ff)
         wsfp_pkg::PH_SECOND: begin
            mask_in = b[7];
            cnt_in  = '0;
            if (code == wsfp_pkg::LEN_CODE_EXT16) begin
               phase_in = wsfp_pkg::PH_EXT16;
            end else if (code == wsfp_pkg::LEN_CODE_EXT64) begin
               phase_in = wsfp_pkg::PH_EXT64;
            end
         end
         wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
            if (!known_now) begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         wsfp_pkg::PH_MASK: begin
            key_in = {key_ff[wsfp_pkg::KEY_W-wsfp_pkg::BYTE_W-1:0], b};
            if (cnt_ff != wsfp_pkg::KEY_LAST_CNT) begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         wsfp_pkg::PH_PAYLOAD: begin
            kp_in  = kp_ff + 2'd1;
            rem_in = rem_ff - {{(wsfp_pkg::ACC_W-1){1'b0}}, 1'b1};
            if (rem_last) begin
               phase_in = wsfp_pkg::PH_FIRST;
            end
         end
         wsfp_pkg::PH_ERROR: begin
            phase_in = wsfp_pkg::PH_ERROR;
         end
         default: begin
            hdr_in   = b;
            key_in   = '0;
            phase_in = wsfp_pkg::PH_SECOND;
         end
      endcase
      // Length complete: check the limit, then read the key or open the payload.
      if (known_now) begin
         if (len_over) begin
            phase_in = wsfp_pkg::PH_ERROR;
         end else if (mask_now) begin
            phase_in = wsfp_pkg::PH_MASK;
            cnt_in   = '0;
         end
      end
      if (hdr_now) begin
         rem_in   = acc_in;
         kp_in    = '0;
         phase_in = len_zero ? wsfp_pkg::PH_FIRST : wsfp_pkg::PH_PAYLOAD;
      end
   end

   // Result
   always_comb begin
      raw_valid          = 1'b0;
      res.kind           = wsfp_pkg::KIND_HEADER;
      res.fin            = hdr_ff[7];
      res.rsv_bits       = hdr_ff[6:4];
      res.opcode         = hdr_ff[3:0];
      res.masked         = mask_now;
      res.payload_length = acc_in[wsfp_pkg::ACC_W-1] ? '1 : acc_in[wsfp_pkg::LEN_W-1:0];
      res.data_byte      = '0;
      res.last_of_frame  = 1'b0;
      if (known_now && len_over) begin
         raw_valid         = 1'b1;
         res.kind          = wsfp_pkg::KIND_ERROR;
         res.last_of_frame = 1'b1;
      end else if (hdr_now) begin
         raw_valid         = 1'b1;
         res.last_of_frame = len_zero;
      end else if (phase_ff == wsfp_pkg::PH_PAYLOAD) begin
         raw_valid         = 1'b1;
         res.kind          = wsfp_pkg::KIND_DATA;
         res.data_byte     = mask_ff ? (b ^ key_byte) : b;
         res.last_of_frame = rem_last;
      end
   end

   assign res_valid = accept && raw_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsfp_pkg::PH_FIRST;
         hdr_ff   <= '0;
         mask_ff  <= 1'b0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         key_ff   <= '0;
         rem_ff   <= '0;
         kp_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         mask_ff  <= mask_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         key_ff   <= key_in;
         rem_ff   <= rem_in;
         kp_ff    <= kp_in;
      end
   end

   `WSFP_NEVER(a_error_silent, clock, reset, (phase_ff == wsfp_pkg::PH_ERROR) && res_valid, "result produced after length error")
   `WSFP_ASSERT(a_error_sticks, clock, reset, res_valid && (res.kind == wsfp_pkg::KIND_ERROR) |=> (phase_ff == wsfp_pkg::PH_ERROR), "error transfer did not enter the error phase")
   `WSFP_ASSERT(a_last_byte_ends, clock, reset, res_valid && (res.kind == wsfp_pkg::KIND_DATA) && res.last_of_frame |=> (phase_ff == wsfp_pkg::PH_FIRST), "frame did not close after its last byte")
   `WSFP_ASSERT(a_empty_closes, clock, reset, res_valid && (res.kind == wsfp_pkg::KIND_HEADER) && (res.payload_length == '0) |-> res.last_of_frame, "empty frame header not flagged last")

endmodule

/* rtl/wsfp_out_reg.sv */
// Result register between the parser and the result channel.
module wsfp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  wsfp_pkg::result_type res,
   output logic                 take_ok,
   wsfp_rsp_if.source           rsp_if
);

   logic                 valid_ff, valid_in;
   wsfp_pkg::result_type data_ff;

   // Take a new result whenever the register is empty or its transfer completes.
   assign take_ok  = !valid_ff || rsp_if.ready;
   assign valid_in = take_ok ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_ok && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.kind           = data_ff.kind;
   assign rsp_if.fin            = data_ff.fin;
   assign rsp_if.rsv_bits       = data_ff.rsv_bits;
   assign rsp_if.opcode         = data_ff.opcode;
   assign rsp_if.masked         = data_ff.masked;
   assign rsp_if.payload_length = data_ff.payload_length;
   assign rsp_if.data_byte      = data_ff.data_byte;
   assign rsp_if.last_of_frame  = data_ff.last_of_frame;

endmodule

/* rtl/websocket_frame_parser.sv */
// WebSocket receive frame parser: one byte in, at most one header, data or error result out.
//
// Takes one stream byte per cycle; its result comes from the result register in the next
// cycle. A new byte is taken every cycle while that register is empty or being drained,
// so throughput is one byte per clock. Header bytes (first byte, length byte, extended
// length, masking key) produce no result until the header is complete, when one header
// result is sent; each payload byte then gives one unmasked data result. The longest path
// is the 64-bit length compare against the limit. A frame longer than the limit gives a
// single error result, after which all input is accepted and dropped until reset. The
// limit register resets to 1024 and should be written only while the parser is idle.
module websocket_frame_parser (
   input  logic       clock,
   input  logic       reset,
   wsfp_req_if.sink   req_if,
   wsfp_rsp_if.source rsp_if,
   wsfp_csr_if.sink   csr_if
);

   logic [wsfp_pkg::LEN_W-1:0] max_len_ff, max_len_in;
   logic                       take_ok;
   logic                       res_valid;
   wsfp_pkg::result_type       res;

   assign csr_if.ready = 1'b1;
   assign max_len_in   = csr_if.valid ? csr_if.data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= wsfp_pkg::MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   wsfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .take_ok   (take_ok),
      .max_len   (max_len_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .take_ok   (take_ok),
      .rsp_if    (rsp_if)
   );

endmodule
